### src/tit_pkg.sv
// Shared types and constants for the tuple interning table.
`default_nettype none
package tit_pkg;
	localparam int unsigned STATUS_BITS = 2;
	localparam logic [STATUS_BITS-1:0] ST_NEW      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EXISTING = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_BAD_ID   = 2'd3;
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_GET = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_SLOT_RD,
		S_SLOT_WAIT,
		S_SLOT_CHK,
		S_TUP_WAIT,
		S_TUP_CHK,
		S_GET_WAIT,
		S_GET_DONE,
		S_OUT
	} tit_state_t;
endpackage
`default_nettype wire

### src/tit_if.sv
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface tit_if #(
	parameter int unsigned W = 8
);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/tit_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tit_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### src/tit_hash.sv
// Iterative tuple hash: one word folded in per cycle through a shared multiplier.
`default_nettype none
module tit_hash #(
	parameter int unsigned MAX_ARGS = 8,
	parameter int unsigned OBJ_BITS = 16,
	parameter int unsigned SLOT_BITS = 11
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [MAX_ARGS*OBJ_BITS-1:0] words,
	output logic                              done,
	output logic      [SLOT_BITS-1:0]         slot
);
	localparam int unsigned IDX_BITS = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
	logic [31:0] h_q;
	logic [IDX_BITS-1:0] idx_q;
	logic busy_q;
	logic [31:0] word;
	logic [31:0] prod;
	logic [31:0] mixed;

	// fold the current word and mix
	always_comb begin
		word = 32'(words[idx_q*OBJ_BITS +: OBJ_BITS]);
		prod = (h_q ^ word) * 32'h9E3779B1;
		mixed = prod ^ (prod >> 15);
	end

	// advance one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			idx_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (busy_q) begin
				if (32'(idx_q) == MAX_ARGS - 1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= 32'h2545F491;
		end else if (busy_q) begin
			h_q <= mixed;
		end
	end

	assign slot = h_q[SLOT_BITS-1:0];
endmodule
`default_nettype wire

### src/tuple_interning_table_core.sv
// Top level of the tuple interning table: sequencer, hash unit and memories.
//
// One request is taken at a time; ready is low while it is in work. A get makes one
// tuple store read. An add first runs the hash (one multiply per tuple word), then
// probes hash slots from the hashed one: each probe reads the slot, waits for the data
// and checks it. An occupied slot leads to a tuple store read and compare, and a slot
// whose tuple differs moves the probe on to the next slot. The result is then held until
// taken, and the table returns to idle. After reset, and after every write of arg_count,
// a clearing pass writes every one of the 2*CAPACITY hash slots empty, one per cycle,
// during which no request is accepted.
`default_nettype none
module tuple_interning_table_core
	import tit_pkg::*;
#(
	parameter int unsigned CAPACITY = 1024,
	parameter int unsigned MAX_ARGS = 8,
	parameter int unsigned OBJ_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [3:0] cfg_wdata,
	tit_if.sink   req,
	tit_if.source rsp
);
	localparam int unsigned ID_BITS = $clog2(CAPACITY);
	localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
	localparam int unsigned SLOTS = 2 * CAPACITY;
	localparam int unsigned SLOT_BITS = $clog2(SLOTS);
	localparam int unsigned TW = MAX_ARGS * OBJ_BITS;
	localparam int unsigned ACW = $clog2(MAX_ARGS + 1);
	// payload layout: req_type, lookup_id, arg words (arg0 lowest)
	localparam int unsigned IN_W = 1 + 10 + 16 * 8;

	tit_state_t state_q, state_d;
	logic [ACW-1:0] arg_count_q;
	logic [TW-1:0] words_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS:0] probes_q;
	logic [CNT_BITS-1:0] count_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [ID_BITS-1:0] id_q;
	logic [TW-1:0] outw_q;
	logic [ID_BITS:0] cand_q;
	logic [3:0] cfg_v;

	logic hash_start, hash_done;
	logic [SLOT_BITS-1:0] hash_slot;
	logic slot_we, tup_we;
	logic [SLOT_BITS-1:0] slot_addr;
	logic [ID_BITS:0] slot_wdata, slot_rdata;
	logic [ID_BITS-1:0] tup_addr;
	logic [TW-1:0] tup_rdata;
	logic [9:0] lid;
	logic lid_ok;

	assign lid = req.data[IN_W-2 -: 10];
	assign lid_ok = (CNT_BITS'(lid) < count_q) && (32'(lid) < CAPACITY);

	// clamp arg_count into range
	always_comb begin
		cfg_v = cfg_wdata;
		if (cfg_v == 4'd0) cfg_v = 4'd1;
		if (32'(cfg_v) > MAX_ARGS) cfg_v = 4'(MAX_ARGS);
	end

	tit_hash #(.MAX_ARGS(MAX_ARGS), .OBJ_BITS(OBJ_BITS), .SLOT_BITS(SLOT_BITS)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hash_start), .words(words_q),
		.done(hash_done), .slot(hash_slot)
	);

	tit_ram #(.WIDTH(ID_BITS + 1), .DEPTH(SLOTS)) u_slots (
		.clk(clk), .we(slot_we), .addr(slot_addr), .wdata(slot_wdata), .rdata(slot_rdata)
	);

	tit_ram #(.WIDTH(TW), .DEPTH(CAPACITY)) u_store (
		.clk(clk), .we(tup_we), .addr(tup_addr), .wdata(words_q), .rdata(tup_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (32'(slot_q) == SLOTS - 1) state_d = S_IDLE;
			S_IDLE: begin
				if (req.valid) state_d = (req.data[IN_W-1] == REQ_GET) ? S_GET_WAIT : S_HASH;
			end
			S_HASH: if (hash_done) state_d = S_SLOT_RD;
			S_SLOT_RD: state_d = S_SLOT_WAIT;
			S_SLOT_WAIT: state_d = S_SLOT_CHK;
			S_SLOT_CHK: begin
				if (slot_rdata == '0 || 32'(probes_q) >= SLOTS) state_d = S_OUT;
				else if (32'(slot_rdata - 1'b1) >= CAPACITY) state_d = S_SLOT_RD;
				else state_d = S_TUP_WAIT;
			end
			S_TUP_WAIT: state_d = S_TUP_CHK;
			S_TUP_CHK: state_d = (tup_rdata == words_q) ? S_OUT : S_SLOT_RD;
			S_GET_WAIT: state_d = S_GET_DONE;
			S_GET_DONE: state_d = S_OUT;
			S_OUT: if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	// memory controls and handshakes
	always_comb begin
		hash_start = 1'b0;
		slot_we = 1'b0;
		tup_we = 1'b0;
		slot_addr = slot_q;
		slot_wdata = '0;
		tup_addr = cand_q[ID_BITS-1:0];
		req.ready = (state_q == S_IDLE) && !cfg_we;
		rsp.valid = (state_q == S_OUT);
		case (state_q)
			S_CLEAR: slot_we = 1'b1;
			S_HASH: hash_start = 1'b0;
			S_SLOT_CHK: begin
				if (slot_rdata == '0 && 32'(probes_q) < SLOTS && 32'(count_q) < CAPACITY) begin
					slot_we = 1'b1;
					slot_wdata = (ID_BITS+1)'(count_q) + 1'b1;
					tup_we = 1'b1;
					tup_addr = count_q[ID_BITS-1:0];
				end else begin
					tup_addr = ID_BITS'(slot_rdata - 1'b1);
				end
			end
			default: ;
		endcase
		if (state_q == S_IDLE && req.valid && req.data[IN_W-1] == REQ_ADD && !cfg_we)
			hash_start = 1'b1;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			arg_count_q <= ACW'(1);
			count_q <= '0;
			slot_q <= '0;
			probes_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: slot_q <= slot_q + 1'b1;
				S_HASH: begin
					// fold the hash into the slot range
					slot_q <= (32'(hash_slot) >= SLOTS) ? hash_slot - SLOT_BITS'(SLOTS)
						: hash_slot;
					probes_q <= '0;
				end
				S_SLOT_CHK: begin
					if (slot_rdata == '0 && 32'(probes_q) < SLOTS && 32'(count_q) < CAPACITY)
						count_q <= count_q + 1'b1;
					if (slot_rdata != '0) begin
						slot_q <= (32'(slot_q) == SLOTS - 1) ? '0 : slot_q + 1'b1;
						probes_q <= probes_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (cfg_we) begin
				arg_count_q <= ACW'(cfg_v);
				count_q <= '0;
				slot_q <= '0;
			end
		end
	end

	// capture the request and build the result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int i = 0; i < MAX_ARGS; i++) begin
					words_q[i*OBJ_BITS +: OBJ_BITS] <= (i < 32'(arg_count_q))
						? OBJ_BITS'(req.data[i*16 +: 16]) : '0;
				end
				cand_q <= (ID_BITS+1)'(lid);
				outw_q <= '0;
				status_q <= lid_ok ? ST_EXISTING : ST_BAD_ID;
				id_q <= lid_ok ? ID_BITS'(lid) : '0;
			end
			S_SLOT_CHK: begin
				cand_q <= slot_rdata - 1'b1;
				if (slot_rdata == '0 || 32'(probes_q) >= SLOTS) begin
					if (slot_rdata == '0 && 32'(probes_q) < SLOTS && 32'(count_q) < CAPACITY) begin
						status_q <= ST_NEW;
						id_q <= count_q[ID_BITS-1:0];
					end else begin
						status_q <= ST_FULL;
						id_q <= '0;
					end
				end
			end
			S_TUP_CHK: begin
				status_q <= ST_EXISTING;
				id_q <= cand_q[ID_BITS-1:0];
			end
			S_GET_DONE: begin
				if (status_q == ST_EXISTING) outw_q <= tup_rdata;
			end
			default: ;
		endcase
	end

	// result payload: status, tuple_id, entry_total, out words (out0 lowest)
	always_comb begin
		rsp.data = '0;
		rsp.data[16*8+22 -: 2] = status_q;
		rsp.data[16*8+20 -: 10] = 10'(id_q);
		rsp.data[16*8+10 -: 11] = 11'(count_q);
		for (int i = 0; i < MAX_ARGS; i++)
			rsp.data[i*16 +: 16] = 16'(outw_q[i*OBJ_BITS +: OBJ_BITS]);
	end

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY) else $error("entry count over capacity");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("ready while result pending");
	a_new_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && status_q == ST_NEW) |-> (count_q != '0))
		else $error("new entry with zero count");
endmodule
`default_nettype wire
